FILE: rtl/core/nearest_neighbor_image_scaler_assert.svh
// Assertion macros shared by the scaler's RTL; they assume clk and rst_n in scope.
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NNIS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NNIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/nnis_pkg.sv
// Types, constants and helper functions of the nearest-neighbour scaler.
package nnis_pkg;

  localparam int MAX_SRC_DIM = 256;
  localparam int MAX_DST_DIM = 1024;
  localparam int PIXEL_BITS  = 32;

  localparam int SRC_DIM_W   = 9;   // holds 1..MAX_SRC_DIM
  localparam int DST_DIM_W   = 11;  // holds 1..MAX_DST_DIM
  localparam int SRC_CRD_W   = 8;   // source coordinate
  localparam int DST_CRD_W   = 10;  // destination coordinate
  localparam int SRC_ADDR_W  = 16;
  localparam int DST_ADDR_W  = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int STORE_DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int DIV_STEPS   = SRC_DIM_W;
  localparam int DIV_CNT_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EMIT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV
  } nnis_state_t;

  typedef struct packed {
    logic                  kind;
    logic [SRC_ADDR_W-1:0] src_addr;
    logic [PIXEL_BITS-1:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [DST_CRD_W-1:0]  dst_x;
    logic [DST_CRD_W-1:0]  dst_y;
    logic [DST_ADDR_W-1:0] dst_addr;
    logic [PIXEL_BITS-1:0] pixel_out;
    logic                  frame_last;
  } out_word_t;

  // A zero dimension counts as one, an oversize one saturates.
  function automatic logic [SRC_DIM_W-1:0] clamp_src(input logic [SRC_DIM_W-1:0] v);
    if (v == '0) begin
      return SRC_DIM_W'(1);
    end
    if (v > SRC_DIM_W'(MAX_SRC_DIM)) begin
      return SRC_DIM_W'(MAX_SRC_DIM);
    end
    return v;
  endfunction

  function automatic logic [DST_DIM_W-1:0] clamp_dst(input logic [DST_DIM_W-1:0] v);
    if (v == '0) begin
      return DST_DIM_W'(1);
    end
    if (v > DST_DIM_W'(MAX_DST_DIM)) begin
      return DST_DIM_W'(MAX_DST_DIM);
    end
    return v;
  endfunction

endpackage

FILE: rtl/core/nnis_if.sv
// Valid/ready channel interfaces for the scaler's input and result words.
interface nnis_in_if
  import nnis_pkg::*;
  ;
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nnis_out_if
  import nnis_pkg::*;
  ;
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/nearest_neighbor_image_scaler.sv
// Nearest-neighbour scaler: a 64K-word source store and a column-by-column
// destination scan. Load words write the store; each emit word fills the result
// register at the clock edge that accepts it, so its destination pixel can be
// taken at the next edge. A new word is taken every cycle while no division
// runs and the result register is free or being drained. The source
// coordinates step by a precomputed quotient and remainder of the size ratios.
// These come from restoring division on both axes in parallel, run after reset
// and after every register write, during which in_ch.ready stays low.
// The single-port-per-side store has no clearing pass; unloaded entries read
// as undefined.
module nearest_neighbor_image_scaler
  import nnis_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  nnis_in_if.sink               in_ch,
  nnis_out_if.source            out_ch
);

  // Configuration registers.
  logic [SRC_DIM_W-1:0] src_width_r, src_height_r;
  logic [DST_DIM_W-1:0] dst_width_r, dst_height_r;
  logic [SRC_DIM_W-1:0] sw_eff, sh_eff;
  logic [DST_DIM_W-1:0] dw_eff, dh_eff;

  // Sequencer and divider.
  nnis_state_t           state_r, state_nxt;
  logic [DIV_CNT_W-1:0]  div_cnt_r;
  logic [SRC_DIM_W-1:0]  quo_x_r, quo_y_r;
  logic [DST_CRD_W-1:0]  rem_x_r, rem_y_r;
  logic [DST_CRD_W:0]    trial_x, trial_y;
  logic                  ge_x, ge_y;

  // Scan state.
  logic [DST_CRD_W-1:0]  col_r, row_r;
  logic [SRC_CRD_W-1:0]  sx_q_r, sy_q_r;
  logic [DST_CRD_W-1:0]  sx_rem_r, sy_rem_r;
  logic [DST_CRD_W:0]    sum_x, sum_y;
  logic                  wrap_x, wrap_y;
  logic                  col_last, row_last;

  // Store, read path and result register.
  logic [PIXEL_BITS-1:0] store_mem [STORE_DEPTH];
  logic [PIXEL_BITS-1:0] rd_data_r;
  logic [SRC_ADDR_W-1:0] rd_addr;
  logic [DST_ADDR_W-1:0] dst_addr;
  logic                  out_valid_r;
  logic [DST_CRD_W-1:0]  dst_x_r, dst_y_r;
  logic [DST_ADDR_W-1:0] dst_addr_r;
  logic                  frame_last_r;

  logic in_fire, emit_fire, load_fire, out_fire;

  assign sw_eff = clamp_src(src_width_r);
  assign sh_eff = clamp_src(src_height_r);
  assign dw_eff = clamp_dst(dst_width_r);
  assign dh_eff = clamp_dst(dst_height_r);

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign emit_fire   = in_fire && (in_ch.data.kind == KIND_EMIT);
  assign load_fire   = in_fire && (in_ch.data.kind == KIND_LOAD);
  assign out_fire    = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_DIM_W'(256);
      src_height_r <= SRC_DIM_W'(256);
      dst_width_r  <= DST_DIM_W'(512);
      dst_height_r <= DST_DIM_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata[SRC_DIM_W-1:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_wdata[SRC_DIM_W-1:0];
        CFG_DST_WIDTH:  dst_width_r  <= cfg_wdata;
        CFG_DST_HEIGHT: dst_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: every register write reloads and reruns the ratio division.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: state_nxt = ST_IDLE;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
    if (cfg_we) begin
      state_nxt = ST_LOAD;
    end
  end

  // One restoring step per cycle on both axes; the final quotient and
  // remainder stay in place as the scan step constants.
  always_comb begin
    trial_x = {rem_x_r, quo_x_r[SRC_DIM_W-1]};
    trial_y = {rem_y_r, quo_y_r[SRC_DIM_W-1]};
    ge_x    = trial_x >= dw_eff;
    ge_y    = trial_y >= dh_eff;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      quo_x_r   <= sw_eff;
      quo_y_r   <= sh_eff;
      rem_x_r   <= '0;
      rem_y_r   <= '0;
      div_cnt_r <= '0;
    end else if (state_r == ST_DIV) begin
      quo_x_r   <= {quo_x_r[SRC_DIM_W-2:0], ge_x};
      quo_y_r   <= {quo_y_r[SRC_DIM_W-2:0], ge_y};
      rem_x_r   <= ge_x ? DST_CRD_W'(trial_x - dw_eff) : trial_x[DST_CRD_W-1:0];
      rem_y_r   <= ge_y ? DST_CRD_W'(trial_y - dh_eff) : trial_y[DST_CRD_W-1:0];
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  // Scan stepping: the source coordinate is kept as quotient plus remainder
  // of d*s/D, so moving one destination pixel adds the ratio's parts.
  always_comb begin
    col_last = {1'b0, col_r} == DST_DIM_W'(dw_eff - DST_DIM_W'(1));
    row_last = {1'b0, row_r} == DST_DIM_W'(dh_eff - DST_DIM_W'(1));
    sum_x    = {1'b0, sx_rem_r} + {1'b0, rem_x_r};
    sum_y    = {1'b0, sy_rem_r} + {1'b0, rem_y_r};
    wrap_x   = sum_x >= dw_eff;
    wrap_y   = sum_y >= dh_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      col_r    <= '0;
      row_r    <= '0;
      sx_q_r   <= '0;
      sy_q_r   <= '0;
      sx_rem_r <= '0;
      sy_rem_r <= '0;
    end else if (emit_fire) begin
      if (!row_last) begin
        row_r    <= row_r + DST_CRD_W'(1);
        sy_rem_r <= wrap_y ? DST_CRD_W'(sum_y - dh_eff) : sum_y[DST_CRD_W-1:0];
        sy_q_r   <= sy_q_r + quo_y_r[SRC_CRD_W-1:0] + SRC_CRD_W'(wrap_y);
      end else begin
        row_r    <= '0;
        sy_rem_r <= '0;
        sy_q_r   <= '0;
        if (col_last) begin
          col_r    <= '0;
          sx_rem_r <= '0;
          sx_q_r   <= '0;
        end else begin
          col_r    <= col_r + DST_CRD_W'(1);
          sx_rem_r <= wrap_x ? DST_CRD_W'(sum_x - dw_eff) : sum_x[DST_CRD_W-1:0];
          sx_q_r   <= sx_q_r + quo_x_r[SRC_CRD_W-1:0] + SRC_CRD_W'(wrap_x);
        end
      end
    end
  end

  assign rd_addr  = SRC_ADDR_W'(sy_q_r * sw_eff) + SRC_ADDR_W'(sx_q_r);
  assign dst_addr = DST_ADDR_W'(row_r * dw_eff) + DST_ADDR_W'(col_r);

  // Source store: the read register only moves on an emit, so it holds the
  // pixel while the result waits.
  always_ff @(posedge clk) begin
    if (load_fire) begin
      store_mem[in_ch.data.src_addr] <= in_ch.data.pixel_in;
    end
    if (emit_fire) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      dst_x_r      <= col_r;
      dst_y_r      <= row_r;
      dst_addr_r   <= dst_addr;
      frame_last_r <= col_last && row_last;
    end
  end

  always_comb begin
    out_ch.valid           = out_valid_r;
    out_ch.data.dst_x      = dst_x_r;
    out_ch.data.dst_y      = dst_y_r;
    out_ch.data.dst_addr   = dst_addr_r;
    out_ch.data.pixel_out  = rd_data_r;
    out_ch.data.frame_last = frame_last_r;
  end

`include "nearest_neighbor_image_scaler_assert.svh"

  `NNIS_ASSERT_NOW(a_busy_blocks_input, state_r != ST_IDLE, !in_ch.ready,
                   "input taken during ratio division")
  `NNIS_ASSERT_NOW(a_scan_in_frame, state_r == ST_IDLE,
                   (col_r < dw_eff) && (row_r < dh_eff), "scan position outside frame")
  `NNIS_ASSERT_NOW(a_rem_below_dim, state_r == ST_IDLE,
                   (sx_rem_r < dw_eff) && (sy_rem_r < dh_eff), "coordinate remainder not reduced")
  `NNIS_ASSERT_NEXT(a_emit_gives_word, emit_fire, out_ch.valid,
                    "emit produced no result word")

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the nearest-neighbour image scaler.
`timescale 1ns / 100ps

module testbench;
  import nnis_pkg::*;

  localparam int unsigned ITEM_TARGET = 550;
  localparam int unsigned RUN_LIMIT   = 500000;

  // Predicts each destination pixel and holds the ones still to come back.
  class scaler_scoreboard;
    bit [PIXEL_BITS-1:0]  src_pixels [int unsigned];
    logic [SRC_DIM_W-1:0] src_w_reg, src_h_reg;
    logic [DST_DIM_W-1:0] dst_w_reg, dst_h_reg;
    int unsigned          col, row;
    out_word_t            due_pixels [$];
    int unsigned          errors, loads, emits, results, frames;

    function new();
      src_w_reg = 9'd256;
      src_h_reg = 9'd256;
      dst_w_reg = 11'd512;
      dst_h_reg = 11'd512;
      col = 0;
      row = 0;
      errors = 0;
      loads = 0;
      emits = 0;
      results = 0;
      frames = 0;
    endfunction

    static function int unsigned fit(int unsigned v, int unsigned top);
      if (v == 0) begin
        return 1;
      end
      return (v > top) ? top : v;
    endfunction

    function void sizes(output int unsigned sw, sh, dw, dh);
      sw = fit(src_w_reg, MAX_SRC_DIM);
      sh = fit(src_h_reg, MAX_SRC_DIM);
      dw = fit(dst_w_reg, MAX_DST_DIM);
      dh = fit(dst_h_reg, MAX_DST_DIM);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SRC_WIDTH: begin
          src_w_reg = val[SRC_DIM_W-1:0];
        end
        CFG_SRC_HEIGHT: begin
          src_h_reg = val[SRC_DIM_W-1:0];
        end
        CFG_DST_WIDTH: begin
          dst_w_reg = val[DST_DIM_W-1:0];
        end
        default: begin
          dst_h_reg = val[DST_DIM_W-1:0];
        end
      endcase
      col = 0;
      row = 0;
    endfunction

    // Store address that the next emit word will read.
    function int unsigned next_read_addr();
      int unsigned sw, sh, dw, dh, c, r;
      sizes(sw, sh, dw, dh);
      c = (col >= dw) ? 0 : col;
      r = (row >= dh) ? 0 : row;
      return ((r * sh) / dh) * sw + (c * sw) / dw;
    endfunction

    function void accept_word(in_word_t w);
      out_word_t   want;
      int unsigned sw, sh, dw, dh, a;
      if (w.kind == KIND_LOAD) begin
        src_pixels[w.src_addr] = w.pixel_in;
        loads++;
        return;
      end
      sizes(sw, sh, dw, dh);
      if (col >= dw) begin
        col = 0;
      end
      if (row >= dh) begin
        row = 0;
      end
      a = next_read_addr();
      want.dst_x      = DST_CRD_W'(col);
      want.dst_y      = DST_CRD_W'(row);
      want.dst_addr   = DST_ADDR_W'(row * dw + col);
      want.pixel_out  = src_pixels.exists(a) ? src_pixels[a] : '0;
      want.frame_last = (col == dw - 1) && (row == dh - 1);
      due_pixels.push_back(want);
      emits++;
      // The scan runs down each column before moving to the next one.
      row++;
      if (row >= dh) begin
        row = 0;
        col++;
        if (col >= dw) begin
          col = 0;
        end
      end
    endfunction

    function void compare_pixel(out_word_t got);
      out_word_t want;
      results++;
      if (due_pixels.size() == 0) begin
        $error("result with no emit outstanding: dst_x %0d, dst_y %0d", got.dst_x, got.dst_y);
        errors++;
        return;
      end
      want = due_pixels.pop_front();
      if (want.frame_last) begin
        frames++;
      end
      if (got.dst_x !== want.dst_x) begin
        $error("dst_x: expected %0d, got %0d", want.dst_x, got.dst_x);
        errors++;
      end
      if (got.dst_y !== want.dst_y) begin
        $error("dst_y: expected %0d, got %0d", want.dst_y, got.dst_y);
        errors++;
      end
      if (got.dst_addr !== want.dst_addr) begin
        $error("dst_addr: expected %0d, got %0d", want.dst_addr, got.dst_addr);
        errors++;
      end
      if (got.pixel_out !== want.pixel_out) begin
        $error("pixel_out: expected %h, got %h", want.pixel_out, got.pixel_out);
        errors++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_last: expected %0d, got %0d", want.frame_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           cycle_count = 0;
  int unsigned           send_calm = 0;
  int unsigned           take_calm = 0;
  bit                    hold_off_request = 1'b0;
  scaler_scoreboard      sb = new();

  nnis_in_if  in_ch ();
  nnis_out_if out_ch ();

  nearest_neighbor_image_scaler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.accept_word(in_ch.data);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.compare_pixel(out_ch.data);
    end
  end

  // Mostly random waits, broken by runs with no waiting at all.
  function automatic int unsigned pick_gap(inout int unsigned calm_left);
    int unsigned gap;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(10, 40);
    end
    return gap;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_src();
    int unsigned r, v;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      v = 0;
    end else if (r == 1) begin
      v = $urandom_range(MAX_SRC_DIM + 1, 511);
    end else if (r == 2) begin
      v = MAX_SRC_DIM;
    end else if (r == 3) begin
      v = $urandom_range(9, MAX_SRC_DIM - 1);
    end else begin
      v = $urandom_range(1, 8);
    end
    // Bits above the register width must be dropped by the block.
    return CFG_DATA_W'(v) | (CFG_DATA_W'($urandom_range(0, 3)) << SRC_DIM_W);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dst();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return CFG_DATA_W'($urandom_range(MAX_DST_DIM + 1, 2047));
    end else if (r == 2) begin
      return CFG_DATA_W'(MAX_DST_DIM);
    end else if (r == 3) begin
      return CFG_DATA_W'($urandom_range(13, MAX_DST_DIM - 1));
    end
    return CFG_DATA_W'($urandom_range(1, 12));
  endfunction

  function automatic in_word_t make_word(logic kind, logic [SRC_ADDR_W-1:0] addr,
                                         logic [PIXEL_BITS-1:0] pix);
    in_word_t w;
    w.kind     = kind;
    w.src_addr = addr;
    w.pixel_in = pix;
    return w;
  endfunction

  // Returns at a falling edge, after the sender's idle time for this word.
  task automatic pace_sender();
    int unsigned gap;
    gap = pick_gap(send_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic offer(input in_word_t w);
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic load_pixel(input logic [SRC_ADDR_W-1:0] addr, input logic [PIXEL_BITS-1:0] pix);
    pace_sender();
    offer(make_word(KIND_LOAD, addr, pix));
  endtask

  // An emit never reads an entry that was never loaded: such an entry is loaded first.
  task automatic emit_pixel();
    int unsigned a;
    pace_sender();
    a = sb.next_read_addr();
    if (!sb.src_pixels.exists(a)) begin
      offer(make_word(KIND_LOAD, SRC_ADDR_W'(a), $urandom));
      pace_sender();
    end
    offer(make_word(KIND_EMIT, SRC_ADDR_W'($urandom), $urandom));
  endtask

  // Waits for every outstanding result, then lets the pipeline empty of loads.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.due_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  // Called at a falling edge while the block is idle.
  task automatic program_regs(input logic [3:0] mask, input logic [CFG_DATA_W-1:0] sw, sh, dw,
                              dh);
    if (mask[0]) begin
      write_reg(CFG_SRC_WIDTH, sw);
    end
    if (mask[1]) begin
      write_reg(CFG_SRC_HEIGHT, sh);
    end
    if (mask[2]) begin
      write_reg(CFG_DST_WIDTH, dw);
    end
    if (mask[3]) begin
      write_reg(CFG_DST_HEIGHT, dh);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : receiver
    int unsigned gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    out_ch.ready <= 1'b1;
    forever begin
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      gap = pick_gap(take_calm);
      // One long hold-off lets the result side back up into the input.
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        gap = 120;
      end
      if (gap > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned sw, sh, dw, dh, n, cut, settings;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_SRC_WIDTH;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    settings = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // The sizes that reset leaves.
    emit_pixel();
    emit_pixel();
    settle();
    // Zero sizes count as one, so every pixel ends a frame.
    program_regs(4'hF, '0, '0, '0, '0);
    emit_pixel();
    emit_pixel();
    load_pixel('0, '0);
    load_pixel('1, '1);
    settle();
    // Every size far beyond its maximum saturates.
    program_regs(4'hF, '1, '1, '1, '1);
    emit_pixel();
    emit_pixel();
    settle();
    // A full small frame and the wrap into the next one.
    program_regs(4'hF, 11'd2, 11'd2, 11'd3, 11'd2);
    repeat (7) emit_pixel();
    settings = 4;

    while (sb.loads + sb.emits < ITEM_TARGET) begin
      settle();
      program_regs(4'($urandom_range(1, 15)), pick_src(), pick_src(), pick_dst(), pick_dst());
      settings++;
      sb.sizes(sw, sh, dw, dh);
      if (sw * sh <= 64 && $urandom_range(0, 1) == 1) begin
        for (int unsigned a = 0; a < sw * sh; a++) begin
          if ($urandom_range(0, 2) != 0) begin
            load_pixel(SRC_ADDR_W'(a), $urandom);
          end
        end
      end
      n = (dw * dh <= 30) ? dw * dh * $urandom_range(1, 2) + $urandom_range(0, 3)
                          : $urandom_range(10, 40);
      if (settings == 6) begin
        n = 60;
        hold_off_request = 1'b1;
      end
      cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : 0;
      for (int unsigned i = 0; i < n; i++) begin
        // Part way through, a single register write restarts the scan.
        if (i == cut && cut != 0) begin
          settle();
          program_regs(4'b0001 << $urandom_range(0, 3), pick_src(), pick_src(), pick_dst(),
                       pick_dst());
        end
        if ($urandom_range(0, 7) == 0) begin
          load_pixel(SRC_ADDR_W'($urandom), $urandom);
        end
        emit_pixel();
      end
    end
    settle();

    $display("Run covered %0d source loads and %0d emits under %0d size settings.",
             sb.loads, sb.emits, settings);
    $display("Checked %0d destination pixels, %0d of them closing a frame.",
             sb.results, sb.frames);
    if (sb.errors == 0 && sb.due_pixels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: nearest_neighbor_image_scaler.f
+incdir+rtl/core
rtl/core/nnis_pkg.sv
rtl/core/nnis_if.sv
rtl/core/nearest_neighbor_image_scaler.sv
sim/testbench.sv
